FILE: rtl/delta_spike_encoder_top_assert.svh
// Assertion macros for the delta spike encoder.
// Uses the clk and rst_n names of the module that includes this header.
`ifndef DELTA_SPIKE_ENCODER_TOP_ASSERT_SVH
`define DELTA_SPIKE_ENCODER_TOP_ASSERT_SVH

// Consequent checked at the same clock edge as the antecedent.
`ifndef SYNTH
`define DSE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define DSE_ASSERT_NOW(label, ante, cons, msg)
`endif

// Consequent checked at the clock edge after the antecedent.
`ifndef SYNTH
`define DSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DSE_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: rtl/dse_pkg.sv
// Shared types and constants of the delta spike encoder.
// No dependencies; used by the top level and its testbench.
package dse_pkg;

    localparam int CHANNEL_BITS         = 6;
    localparam int SAMPLE_BITS          = 12;
    localparam int THR_BITS             = 8;
    localparam int ACC_BITS             = 9;
    localparam int MAP_BITS             = 64;
    localparam int NUM_CHANNELS_DEFAULT = 64;

    localparam logic [THR_BITS-1:0] THRESHOLD_RESET = 8'd100;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;

    // Register indexes of the configuration port.
    localparam logic [REG_IDX_BITS-1:0] REG_THRESHOLD = 1'd0;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] channel;
        logic [SAMPLE_BITS-1:0]  sample;
        logic                    frame_end;
    } dse_item_t;

    typedef struct packed {
        logic [MAP_BITS-1:0] up_spikes;
        logic [MAP_BITS-1:0] down_spikes;
    } dse_spikes_t;

    // One word of the per-channel state memory.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0]    prev;
        logic signed [ACC_BITS-1:0] acc;
    } dse_entry_t;

endpackage

FILE: rtl/dse_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module dse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/delta_spike_encoder_top.sv
// Delta spike encoder top level: per-channel send-on-delta spike detection.
// Depends on dse_pkg, dse_ram and delta_spike_encoder_top_assert.svh.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+---------------------------------
//  item     | item_valid / item_stall  | dse_item_t (channel, sample, frame_end)
//  spike    | spike_valid / spike_stall| dse_spikes_t (up_spikes, down_spikes)
//  config   | APB (psel, penable, ...) | spike_threshold at byte address 0
//
// One item is taken every cycle unless a frame-end request waits on a stalled result.
// The state memory read is registered, so the read and the update fall in separate stages,
// with the previous item's write forwarded when both name the same channel.
// After reset all channel state reads as zero through per-entry valid bits; no clearing pass.
// A stalled result holds in the output register; only a further frame-end request waits.
`include "delta_spike_encoder_top_assert.svh"

module delta_spike_encoder_top #(
    parameter int NUM_CHANNELS = dse_pkg::NUM_CHANNELS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  dse_pkg::dse_item_t                  item,
    output logic                                spike_valid,
    input  logic                                spike_stall,
    output dse_pkg::dse_spikes_t                spike,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dse_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [dse_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [dse_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready
);

    import dse_pkg::*;

    localparam int CH_AW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int ENTRY_W = $bits(dse_entry_t);
    localparam int SUM_W   = SAMPLE_BITS + 2;

    // Configuration register.
    logic [THR_BITS-1:0]     thr_reg;
    logic [REG_IDX_BITS-1:0] reg_idx;
    logic                    cfg_write;

    // Stage one: item waiting for its state read.
    dse_item_t            s1_reg;
    logic                 s1_valid_reg;
    logic                 fwd_hit_reg;
    logic                 fwd_hit_next;
    dse_entry_t           fwd_entry_reg;
    logic                 ent_hit_reg;
    logic [NUM_CHANNELS-1:0] ent_valid_reg;

    // Spike bitmaps and result register.
    logic [MAP_BITS-1:0] up_map_reg;
    logic [MAP_BITS-1:0] down_map_reg;
    logic [MAP_BITS-1:0] up_map_next;
    logic [MAP_BITS-1:0] down_map_next;
    logic                spike_valid_reg;
    dse_spikes_t         spike_reg;

    logic accept;
    logic blocked;
    logic fire;
    logic in_range;
    logic wr_en;
    logic same_channel;

    logic [CH_AW-1:0]   rd_addr;
    logic [CH_AW-1:0]   wr_addr;
    logic [ENTRY_W-1:0] rd_word;
    dse_entry_t         rd_entry;
    dse_entry_t         cur_entry;
    dse_entry_t         new_entry;

    logic signed [SUM_W-1:0] jump_w;
    logic signed [SUM_W-1:0] acc_w;
    logic signed [SUM_W-1:0] sum_w;
    logic signed [SUM_W-1:0] lim_w;
    logic signed [SUM_W-1:0] neg_lim_w;
    logic                    jump_up;
    logic                    jump_down;
    logic                    fire_up;
    logic                    fire_down;
    logic [MAP_BITS-1:0]     chan_bit;

    // ---------------------------------------------------------------- config port
    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (reg_idx == REG_THRESHOLD) ? APB_DATA_BITS'(thr_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESHOLD_RESET;
        end
        else if (cfg_write && (reg_idx == REG_THRESHOLD))
        begin
            thr_reg <= pwdata[THR_BITS-1:0];
        end
    end

    // ---------------------------------------------------------------- handshake
    // Only a frame-end request needs the output register; others pass a waiting result.
    assign blocked    = s1_valid_reg && s1_reg.frame_end && spike_valid_reg && spike_stall;
    assign item_stall = blocked;
    assign accept     = item_valid && !item_stall;
    assign fire       = s1_valid_reg && !blocked;
    assign in_range   = {1'b0, s1_reg.channel} < (CHANNEL_BITS + 1)'(NUM_CHANNELS);
    assign wr_en      = fire && in_range;

    assign rd_addr = item.channel[CH_AW-1:0];
    assign wr_addr = s1_reg.channel[CH_AW-1:0];

    // The write of the item leaving stage one misses the read issued at the same edge.
    assign same_channel = (s1_reg.channel == item.channel);

    always_comb
    begin
        if (accept)
        begin
            fwd_hit_next = wr_en && same_channel;
        end
        else if (fire)
        begin
            fwd_hit_next = 1'b0;
        end
        else
        begin
            fwd_hit_next = fwd_hit_reg;
        end
    end

    dse_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_CHANNELS)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (new_entry),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    assign rd_entry = rd_word;

    always_comb
    begin
        if (fwd_hit_reg)
        begin
            cur_entry = fwd_entry_reg;
        end
        else if (ent_hit_reg)
        begin
            cur_entry = rd_entry;
        end
        else
        begin
            cur_entry = '0;
        end
    end

    // ---------------------------------------------------------------- spike decision
    assign jump_w    = $signed({2'b00, s1_reg.sample} - {2'b00, cur_entry.prev});
    assign acc_w     = {{(SUM_W - ACC_BITS){cur_entry.acc[ACC_BITS-1]}}, cur_entry.acc};
    assign sum_w     = jump_w + acc_w;
    assign lim_w     = {{(SUM_W - THR_BITS){1'b0}}, thr_reg};
    assign neg_lim_w = -lim_w;

    assign jump_up   = jump_w > lim_w;
    assign jump_down = jump_w < neg_lim_w;
    assign fire_up   = jump_up || (!jump_down && (sum_w > lim_w));
    assign fire_down = jump_down || (!jump_up && (sum_w < neg_lim_w));

    assign new_entry.prev = s1_reg.sample;
    assign new_entry.acc  = (fire_up || fire_down) ? '0 : sum_w[ACC_BITS-1:0];

    assign chan_bit = MAP_BITS'(1) << s1_reg.channel;

    always_comb
    begin
        up_map_next   = up_map_reg;
        down_map_next = down_map_reg;
        if (wr_en && fire_up)
        begin
            up_map_next = up_map_reg | chan_bit;
        end
        if (wr_en && fire_down)
        begin
            down_map_next = down_map_reg | chan_bit;
        end
    end

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            fwd_hit_reg     <= 1'b0;
            ent_valid_reg   <= '0;
            up_map_reg      <= '0;
            down_map_reg    <= '0;
            spike_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_hit_reg <= fwd_hit_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                ent_valid_reg[wr_addr] <= 1'b1;
            end
            if (fire)
            begin
                if (s1_reg.frame_end)
                begin
                    up_map_reg   <= '0;
                    down_map_reg <= '0;
                end
                else
                begin
                    up_map_reg   <= up_map_next;
                    down_map_reg <= down_map_next;
                end
            end
            if (fire && s1_reg.frame_end)
            begin
                spike_valid_reg <= 1'b1;
            end
            else if (!spike_stall)
            begin
                spike_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg        <= item;
            fwd_entry_reg <= new_entry;
            ent_hit_reg   <= ent_valid_reg[rd_addr];
        end
        if (fire && s1_reg.frame_end)
        begin
            spike_reg.up_spikes   <= up_map_next;
            spike_reg.down_spikes <= down_map_next;
        end
    end

    assign spike_valid = spike_valid_reg;
    assign spike       = spike_reg;

    // ---------------------------------------------------------------- assertions
    `DSE_ASSERT_NOW(a_stall_only_on_held_result, item_stall, spike_valid && spike_stall, "stall without a held result")
    `DSE_ASSERT_NOW(a_result_from_frame_end, spike_valid && !$past(spike_valid), $past(fire && s1_reg.frame_end), "result without frame end")
    `DSE_ASSERT_NOW(a_forward_needs_item, fwd_hit_reg, s1_valid_reg, "forward flag with empty stage")
    `DSE_ASSERT_NEXT(a_written_entry_valid, wr_en, ent_valid_reg[$past(wr_addr)], "written entry not marked valid")

endmodule

FILE: sim/tb.sv
// Self-checking testbench for delta_spike_encoder_top: random-paced sample requests,
// a stalling spike reader and a built-in send-on-delta predictor.
// Depends on dse_pkg and the RTL of the encoder.
`timescale 1ns / 1ps

module tb;
    import dse_pkg::*;

    localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_ITEMS    = 170;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_ALTERNATE} stall_mode_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     item_valid = 1'b0;
    logic                     item_stall;
    dse_item_t                item = '0;
    logic                     spike_valid;
    logic                     spike_stall = 1'b0;
    dse_spikes_t              spike;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    // Requests waiting to be offered, and spike maps due from the block.
    dse_item_t   sample_queue[$];
    dse_spikes_t frame_maps_due[$];

    // Predicted encoder state.
    logic [SAMPLE_BITS-1:0] last_sample [MAP_BITS];
    int                     drift [MAP_BITS];
    logic [MAP_BITS-1:0]    up_map;
    logic [MAP_BITS-1:0]    down_map;
    int                     threshold_now;

    // Level last queued per channel, so that stimulus can aim at the threshold band.
    logic [SAMPLE_BITS-1:0] scan_level [MAP_BITS];

    int          fault_count = 0;
    int          idle_cycles = 0;
    int          gap_left = 0;
    int          burst_left = 0;
    int          hold_ticket = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          segment_left = 0;
    stall_mode_t stall_mode = STALL_NONE;

    delta_spike_encoder_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .spike_valid (spike_valid),
        .spike_stall (spike_stall),
        .spike       (spike),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void report_fault(string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // Send-on-delta update of one channel; a frame end yields the gathered maps.
    function automatic void encode_request(dse_item_t req);
        int          jump;
        int          sum;
        dse_spikes_t maps;
        jump = int'(req.sample) - int'(last_sample[req.channel]);
        if (jump > threshold_now)
        begin
            up_map[req.channel] = 1'b1;
            drift[req.channel] = 0;
        end
        else if (jump < -threshold_now)
        begin
            down_map[req.channel] = 1'b1;
            drift[req.channel] = 0;
        end
        else
        begin
            sum = drift[req.channel] + jump;
            if (sum > threshold_now)
            begin
                up_map[req.channel] = 1'b1;
                sum = 0;
            end
            else if (sum < -threshold_now)
            begin
                down_map[req.channel] = 1'b1;
                sum = 0;
            end
            drift[req.channel] = sum;
        end
        last_sample[req.channel] = req.sample;
        if (req.frame_end)
        begin
            maps.up_spikes = up_map;
            maps.down_spikes = down_map;
            frame_maps_due.push_back(maps);
            up_map = '0;
            down_map = '0;
        end
    endfunction

    function automatic void push_item(int ch, int level, bit last);
        dse_item_t req;
        req.channel = ch[CHANNEL_BITS-1:0];
        req.sample = level[SAMPLE_BITS-1:0];
        req.frame_end = last;
        scan_level[ch] = level[SAMPLE_BITS-1:0];
        sample_queue.push_back(req);
    endfunction

    // Mostly steps near the threshold or small drifts that build up; some wild readings.
    function automatic int next_level(int ch, int thr);
        int pick;
        int delta;
        int level;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            delta = int'($urandom_range(0, 2 * thr + 4)) - (thr + 2);
        else if (pick < 75)
            delta = int'($urandom_range(0, thr / 2 + 1));
        else if (pick < 85)
            delta = thr + int'($urandom_range(0, 1));
        else
            return int'($urandom_range(0, SAMPLE_MAX));
        if (pick >= 45 && $urandom_range(0, 1) == 1)
            delta = -delta;
        level = int'(scan_level[ch]) + delta;
        if (level < 0)
            level = 0;
        if (level > SAMPLE_MAX)
            level = SAMPLE_MAX;
        return level;
    endfunction

    task automatic queue_random_phase(int count, int thr);
        int hot [4];
        int ch;
        foreach (hot[k])
            hot[k] = $urandom_range(0, MAP_BITS - 1);
        repeat (count)
        begin
            if ($urandom_range(0, 9) < 7)
                ch = hot[$urandom_range(0, 3)];
            else
                ch = $urandom_range(0, MAP_BITS - 1);
            push_item(ch, next_level(ch, thr), $urandom_range(0, 7) == 0);
        end
    endtask

    // Threshold write followed by a read-back, both on the APB port.
    task automatic set_threshold(int value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_THRESHOLD, 2'b00};
        pwdata <= APB_DATA_BITS'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        threshold_now = value;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[THR_BITS-1:0] != value[THR_BITS-1:0])
            report_fault($sformatf("threshold read-back: expected %0d, got %0d",
                                   value, prdata[THR_BITS-1:0]));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_until_drained();
        while (sample_queue.size() != 0 || item_valid || frame_maps_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Sample sender: bursts of requests with random gaps; a stalled request is held.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else if (!item_valid || !item_stall)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                item_valid <= 1'b0;
            end
            else if (sample_queue.size() != 0)
            begin
                item <= sample_queue.pop_front();
                item_valid <= 1'b1;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Spike reader: stall pattern changes from segment to segment, plus the long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spike_stall <= 1'b0;
        end
        else
        begin
            if (hold_seen != hold_ticket)
            begin
                hold_seen = hold_ticket;
                hold_left = HOLD_CYCLES;
            end
            if (segment_left == 0)
            begin
                segment_left = $urandom_range(20, 200);
                stall_mode = stall_mode_t'($urandom_range(0, 3));
            end
            segment_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                spike_stall <= 1'b1;
            end
            else
            begin
                case (stall_mode)
                    STALL_NONE:      spike_stall <= 1'b0;
                    STALL_LIGHT:     spike_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:     spike_stall <= ($urandom_range(0, 3) != 0);
                    default:         spike_stall <= ~spike_stall;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            encode_request(item);
    end

    always @(posedge clk)
    begin
        if (rst_n && spike_valid && !spike_stall)
        begin
            if (frame_maps_due.size() == 0)
            begin
                report_fault($sformatf("unexpected spike maps: up %h down %h",
                                       spike.up_spikes, spike.down_spikes));
            end
            else
            begin
                if (spike.up_spikes != frame_maps_due[0].up_spikes)
                    report_fault($sformatf("up_spikes: expected %h, got %h",
                                           frame_maps_due[0].up_spikes, spike.up_spikes));
                if (spike.down_spikes != frame_maps_due[0].down_spikes)
                    report_fault($sformatf("down_spikes: expected %h, got %h",
                                           frame_maps_due[0].down_spikes, spike.down_spikes));
                void'(frame_maps_due.pop_front());
            end
        end
    end

    // Ends the run when no request of any kind has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (spike_valid && !spike_stall) || psel)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int thresholds [6];
        for (int c = 0; c < MAP_BITS; c++)
        begin
            last_sample[c] = '0;
            drift[c] = 0;
            scan_level[c] = '0;
        end
        up_map = '0;
        down_map = '0;
        threshold_now = int'(THRESHOLD_RESET);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames at the reset threshold of 100.
        @(negedge clk);
        push_item(0, SAMPLE_MAX, 1'b0);
        push_item(63, 101, 1'b0);
        push_item(1, 100, 1'b0);
        push_item(1, 101, 1'b1);
        push_item(0, 0, 1'b0);
        push_item(63, 1, 1'b0);
        push_item(63, 0, 1'b0);
        push_item(5, 4000, 1'b0);
        push_item(5, 0, 1'b1);
        push_item(2, 0, 1'b1);
        push_item(7, 50, 1'b1);
        push_item(7, 0, 1'b0);
        push_item(7, 2048, 1'b1);
        push_item(62, SAMPLE_MAX, 1'b0);
        push_item(62, SAMPLE_MAX - 100, 1'b0);
        push_item(62, SAMPLE_MAX - 1, 1'b1);

        thresholds[0] = 255;
        thresholds[1] = 0;
        thresholds[2] = 1;
        thresholds[3] = $urandom_range(2, 254);
        thresholds[4] = $urandom_range(2, 254);
        thresholds[5] = 100;
        foreach (thresholds[p])
        begin
            wait_until_drained();
            set_threshold(thresholds[p]);
            @(negedge clk);
            queue_random_phase(PHASE_ITEMS, thresholds[p]);
            // Hold the reader off so that results back up into the input.
            if (p == 4)
                hold_ticket++;
        end

        wait_until_drained();
        if (frame_maps_due.size() != 0)
            report_fault($sformatf("%0d spike maps never arrived", frame_maps_due.size()));
        if (fault_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
